// ===== hw/rtl/oversample_autorange_scaler_defines.svh =====
// ---------------------------------------------------------------------------
// oversample_autorange_scaler defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef OVERSAMPLE_AUTORANGE_SCALER_DEFINES_SVH
`define OVERSAMPLE_AUTORANGE_SCALER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define OSAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define OSAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/osar_pkg.sv =====
// ---------------------------------------------------------------------------
// osar_pkg
// shared constants and types of the oversample autorange scaler
// ---------------------------------------------------------------------------
package osar_pkg;

    localparam int SAMPLE_BITS         = 12;
    localparam int MAX_OS_LOG2_INT     = 8;
    localparam int OS_LOG2_W           = 4;
    localparam int CNT_W               = MAX_OS_LOG2_INT + 1;
    localparam int SUM_W               = SAMPLE_BITS + MAX_OS_LOG2_INT;
    localparam int PROD_W              = 2 * SAMPLE_BITS;
    localparam int STEP_W              = 4;
    localparam int CFG_IDX_W           = 2;

    localparam logic [OS_LOG2_W-1:0]   MAX_OS_LOG2      = OS_LOG2_W'(MAX_OS_LOG2_INT);
    localparam logic [OS_LOG2_W-1:0]   OS_LOG2_RESET    = OS_LOG2_W'(6);
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RESET = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] MIN_RESET        = SAMPLE_BITS'(4090);
    localparam logic [STEP_W-1:0]      DIV_LAST_STEP    = STEP_W'(SAMPLE_BITS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OS_LOG2    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = CFG_IDX_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_AVG  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

endpackage

// ===== hw/rtl/oversample_autorange_scaler.sv =====
// ---------------------------------------------------------------------------
// oversample_autorange_scaler
// oversampling averager with running min/max autorange and linear scaling
// ---------------------------------------------------------------------------
// usage
//   sample channel: i_sample_valid / o_sample_ready carry one raw reading per
//   request. samples are summed in groups of 2^oversample_log2 (clamped to 8)
//   result channel: o_result_valid / i_result_ready carry one result per group
//   config port: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 oversample_log2, which also drops the partial group; 1 full_scale)
// sequence
//   a sample that does not close a group is accepted, ready stays high
//   the sample that closes a group holds off the next one until these steps are done:
//   accept, average and min/max, multiply, 12 steps of the restoring
//   divider (one quotient bit per cycle), load of the result register
// reset: sums, counts and the last scaled value clear, min 4090, max 0,
//   registers back to 6 and 2048, no result pending
// stall: the result register holds until taken; further non-closing samples
//   are still accepted, a closing one waits in the load step until it frees
// ---------------------------------------------------------------------------
module oversample_autorange_scaler (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample channel
    input  logic                                   i_sample_valid,
    output logic                                   o_sample_ready,
    input  logic [osar_pkg::SAMPLE_BITS-1:0]       i_sample,
    // result channel
    output logic                                   o_result_valid,
    input  logic                                   i_result_ready,
    output logic [osar_pkg::SAMPLE_BITS-1:0]       o_average,
    output logic [osar_pkg::SAMPLE_BITS-1:0]       o_scaled,
    output logic [osar_pkg::SAMPLE_BITS-1:0]       o_low_seen,
    output logic [osar_pkg::SAMPLE_BITS-1:0]       o_high_seen,
    output logic                                   o_changed,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [osar_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [osar_pkg::SAMPLE_BITS-1:0]       i_cfg_wdata
);

    // configuration registers
    logic [osar_pkg::OS_LOG2_W-1:0]   r_os_log2,    n_os_log2;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_full_scale, n_full_scale;

    // accumulation and calibration state
    logic [osar_pkg::SUM_W-1:0]       r_sum,  n_sum;
    logic [osar_pkg::CNT_W-1:0]       r_cnt,  n_cnt;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_min,  n_min;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_max,  n_max;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_last, n_last;

    // sequencer
    osar_pkg::t_state                 r_state, n_state;
    logic [osar_pkg::STEP_W-1:0]      r_step,  n_step;

    // datapath registers (no reset needed)
    logic [osar_pkg::SAMPLE_BITS-1:0] r_avg,  n_avg;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_span, n_span;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_rem,  n_rem;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_dvd,  n_dvd;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_quo,  n_quo;

    // result register
    logic                             r_out_valid, n_out_valid;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_out_avg,   n_out_avg;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_out_scl,   n_out_scl;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_out_low,   n_out_low;
    logic [osar_pkg::SAMPLE_BITS-1:0] r_out_high,  n_out_high;
    logic                             r_out_chg,   n_out_chg;

    // combinational helpers
    logic [osar_pkg::OS_LOG2_W-1:0]   w_k;
    logic [osar_pkg::CNT_W-1:0]       w_group_size;
    logic [osar_pkg::SUM_W-1:0]       w_sum_next;
    logic [osar_pkg::CNT_W-1:0]       w_cnt_next;
    logic [osar_pkg::SUM_W-1:0]       w_sum_shift;
    logic [osar_pkg::SAMPLE_BITS-1:0] w_avg;
    logic [osar_pkg::SAMPLE_BITS-1:0] w_offset;
    logic [osar_pkg::PROD_W-1:0]      w_prod;
    logic [osar_pkg::SAMPLE_BITS:0]   w_trial;
    logic [osar_pkg::SAMPLE_BITS:0]   w_diff;
    logic [osar_pkg::SAMPLE_BITS-1:0] w_scaled;
    logic                             w_sample_req;

    // oversample ratio above the supported maximum is clamped
    assign w_k          = (r_os_log2 > osar_pkg::MAX_OS_LOG2) ? osar_pkg::MAX_OS_LOG2
                                                              : r_os_log2;
    assign w_group_size = osar_pkg::CNT_W'(1) << w_k;
    assign w_sum_next   = r_sum + osar_pkg::SUM_W'(i_sample);
    assign w_cnt_next   = r_cnt + osar_pkg::CNT_W'(1);

    // average of the completed group
    assign w_sum_shift  = r_sum >> w_k;
    assign w_avg        = w_sum_shift[osar_pkg::SAMPLE_BITS-1:0];

    // (avg - min) * full_scale, min already widened so the offset is never negative
    assign w_offset     = r_avg - r_min;
    assign w_prod       = osar_pkg::PROD_W'(w_offset) * osar_pkg::PROD_W'(r_full_scale);

    // one restoring divider step: bring down the next dividend bit, try span
    assign w_trial      = {r_rem, r_dvd[osar_pkg::SAMPLE_BITS-1]};
    assign w_diff       = w_trial - {1'b0, r_span};

    // flat range gives zero
    assign w_scaled     = (r_span == '0) ? '0 : r_quo;

    assign w_sample_req = i_sample_valid && o_sample_ready;

    always_comb begin
        n_os_log2    = r_os_log2;
        n_full_scale = r_full_scale;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_min        = r_min;
        n_max        = r_max;
        n_last       = r_last;
        n_state      = r_state;
        n_step       = r_step;
        n_avg        = r_avg;
        n_span       = r_span;
        n_rem        = r_rem;
        n_dvd        = r_dvd;
        n_quo        = r_quo;
        n_out_valid  = r_out_valid;
        n_out_avg    = r_out_avg;
        n_out_scl    = r_out_scl;
        n_out_low    = r_out_low;
        n_out_high   = r_out_high;
        n_out_chg    = r_out_chg;

        // result taken by the receiver
        if (r_out_valid && i_result_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            osar_pkg::ST_IDLE: begin
                if (w_sample_req) begin
                    n_sum = w_sum_next;
                    n_cnt = w_cnt_next;
                    // group closes: hand the full sum to the average step
                    if (w_cnt_next == w_group_size) begin
                        n_state = osar_pkg::ST_AVG;
                    end
                end
            end
            osar_pkg::ST_AVG: begin
                n_avg   = w_avg;
                n_sum   = '0;
                n_cnt   = '0;
                n_min   = (w_avg < r_min) ? w_avg : r_min;
                n_max   = (w_avg > r_max) ? w_avg : r_max;
                n_state = osar_pkg::ST_MUL;
            end
            osar_pkg::ST_MUL: begin
                // quotient fits in 12 bits, so the upper half is below span
                n_rem   = w_prod[osar_pkg::PROD_W-1:osar_pkg::SAMPLE_BITS];
                n_dvd   = w_prod[osar_pkg::SAMPLE_BITS-1:0];
                n_span  = r_max - r_min;
                n_step  = '0;
                n_state = osar_pkg::ST_DIV;
            end
            osar_pkg::ST_DIV: begin
                if (!w_diff[osar_pkg::SAMPLE_BITS]) begin
                    n_rem = w_diff[osar_pkg::SAMPLE_BITS-1:0];
                    n_quo = {r_quo[osar_pkg::SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[osar_pkg::SAMPLE_BITS-1:0];
                    n_quo = {r_quo[osar_pkg::SAMPLE_BITS-2:0], 1'b0};
                end
                n_dvd  = {r_dvd[osar_pkg::SAMPLE_BITS-2:0], 1'b0};
                n_step = r_step + osar_pkg::STEP_W'(1);
                if (r_step == osar_pkg::DIV_LAST_STEP) begin
                    n_state = osar_pkg::ST_OUT;
                end
            end
            osar_pkg::ST_OUT: begin
                // load once the result register is free or being emptied
                if (!r_out_valid || i_result_ready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_scl   = w_scaled;
                    n_out_low   = r_min;
                    n_out_high  = r_max;
                    n_out_chg   = (w_scaled != r_last);
                    n_last      = w_scaled;
                    n_state     = osar_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = osar_pkg::ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block itself does not enforce this
        if (i_cfg_we) begin
            case (i_cfg_idx)
                osar_pkg::CFG_OS_LOG2: begin
                    n_os_log2 = i_cfg_wdata[osar_pkg::OS_LOG2_W-1:0];
                    n_sum     = '0;
                    n_cnt     = '0;
                end
                osar_pkg::CFG_FULL_SCALE: begin
                    n_full_scale = i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // control and calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_os_log2    <= osar_pkg::OS_LOG2_RESET;
            r_full_scale <= osar_pkg::FULL_SCALE_RESET;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_min        <= osar_pkg::MIN_RESET;
            r_max        <= '0;
            r_last       <= '0;
            r_state      <= osar_pkg::ST_IDLE;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_os_log2    <= n_os_log2;
            r_full_scale <= n_full_scale;
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
            r_min        <= n_min;
            r_max        <= n_max;
            r_last       <= n_last;
            r_state      <= n_state;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_avg      <= n_avg;
        r_span     <= n_span;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_quo      <= n_quo;
        r_out_avg  <= n_out_avg;
        r_out_scl  <= n_out_scl;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_chg  <= n_out_chg;
    end

    assign o_sample_ready = (r_state == osar_pkg::ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_average      = r_out_avg;
    assign o_scaled       = r_out_scl;
    assign o_low_seen     = r_out_low;
    assign o_high_seen    = r_out_high;
    assign o_changed      = r_out_chg;

endmodule

// ===== hw/rtl/osar_checker.sv =====
// ---------------------------------------------------------------------------
// osar_checker
// port-level checks of the oversample autorange scaler
// ---------------------------------------------------------------------------
`include "oversample_autorange_scaler_defines.svh"

module osar_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_sample_valid,
    input logic                             o_sample_ready,
    input logic [osar_pkg::SAMPLE_BITS-1:0] i_sample,
    input logic                             o_result_valid,
    input logic                             i_result_ready,
    input logic [osar_pkg::SAMPLE_BITS-1:0] o_average,
    input logic [osar_pkg::SAMPLE_BITS-1:0] o_scaled,
    input logic [osar_pkg::SAMPLE_BITS-1:0] o_low_seen,
    input logic [osar_pkg::SAMPLE_BITS-1:0] o_high_seen,
    input logic                             o_changed,
    input logic                             i_cfg_we,
    input logic [osar_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [osar_pkg::SAMPLE_BITS-1:0] i_cfg_wdata
);

    // stalled result holds
    `OSAR_ASSERT_NEXT(a_result_hold, o_result_valid && !i_result_ready, o_result_valid && $stable(o_average) && $stable(o_scaled) && $stable(o_low_seen) && $stable(o_high_seen) && $stable(o_changed), "result changed while stalled")

    // the running range always covers the current average
    `OSAR_ASSERT_NOW(a_range_covers, o_result_valid, (o_low_seen <= o_average) && (o_average <= o_high_seen), "average outside running range")

    // flat range maps to zero
    `OSAR_ASSERT_NOW(a_flat_zero, o_result_valid && (o_low_seen == o_high_seen), o_scaled == '0, "flat range not scaled to zero")

    // an average at the minimum maps to zero
    `OSAR_ASSERT_NOW(a_min_zero, o_result_valid && (o_average == o_low_seen), o_scaled == '0, "average at minimum not scaled to zero")

endmodule

bind oversample_autorange_scaler osar_checker u_osar_checker (.*);
